### rtl/core/stkx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkx_pkg
// Shared codes, state and command types for the streaming top-K store.
// ----------------------------------------------------------------------------
package stkx_pkg;

    // Request operation codes.
    localparam logic [1:0] OP_OBSERVE = 2'd0;
    localparam logic [1:0] OP_REPORT  = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_EXPIRED   = 3'd0;
    localparam logic [2:0] KIND_DISPLACED = 3'd1;
    localparam logic [2:0] KIND_STATUS    = 3'd2;
    localparam logic [2:0] KIND_REPORT    = 3'd3;
    localparam logic [2:0] KIND_EMPTY     = 3'd4;
    localparam logic [2:0] KIND_CLEAR     = 3'd5;

    // Observe outcomes.
    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_REPLACED = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    // Register indexes.
    localparam logic REG_K_IN_USE = 1'b0;
    localparam logic REG_TTL      = 1'b1;

    localparam logic [4:0]  K_RESET   = 5'd10;
    localparam logic [23:0] TTL_RESET = 24'd3600;

    typedef enum logic [4:0] {
        S_IDLE, S_EXP_RD, S_EXP_CHK, S_EXP_MRD, S_EXP_MLD,
        S_SD_RDL, S_SD_CHL, S_SD_CHR, S_SD_DEC, S_WR_CUR,
        S_SU_RDP, S_SU_CHP, S_SRCH_RD, S_SRCH_CHK, S_DEC_RD,
        S_DECIDE, S_UPD_RD, S_UPD_LD, S_STAT, S_RPT_INIT,
        S_RPT_SI, S_RPT_RD, S_RPT_CHK, S_RPT_EMIT, S_CLR_RD,
        S_CLR_PUSH, S_CLR_DONE, S_DRN_RD, S_DRN_OUT, S_DRN_WAIT
    } t_state;

    typedef enum logic [5:0] {
        DP_NOP, DP_LOAD, DP_EXP_RD, DP_EXP_CHK, DP_EXP_MRD, DP_EXP_MLD,
        DP_SD_RDL, DP_SD_CHL, DP_SD_CHR, DP_SD_DEC, DP_WR_CUR,
        DP_SU_RDP, DP_SU_CHP, DP_SRCH_RD, DP_SRCH_CHK, DP_DEC_RD,
        DP_DEC_UPD, DP_DEC_INS, DP_DEC_REP, DP_DEC_DROP, DP_UPD_RD,
        DP_UPD_LD, DP_STAT, DP_RPT_INIT, DP_RPT_SI, DP_RPT_RD,
        DP_RPT_CHK, DP_RPT_EMIT, DP_CLR_RD, DP_CLR_PUSH, DP_CLR_DONE,
        DP_DRN_RD, DP_DRN_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic held_zero;
        logic held_one;
        logic j_end;
        logic expired;
        logic l_ok;
        logic r_ok;
        logic s_is_i;
        logic i_zero;
        logic key_match;
        logic found;
        logic room;
        logic beats;
        logic up_less;
        logic rpt_last;
        logic drn_last;
        logic out_done;
    } t_dp_sts;

endpackage

### rtl/core/stkx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkx_ctrl
// Sequencer for expiry, key search, heap sifts, sorted report, clear and drain.
// ----------------------------------------------------------------------------
module stkx_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_op,
    input  stkx_pkg::t_dp_sts i_sts,
    output stkx_pkg::t_dp_cmd o_cmd,
    output logic             o_in_ready
);
    import stkx_pkg::*;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_op)
                        OP_OBSERVE: n_state = S_EXP_RD;
                        OP_REPORT:  n_state = S_RPT_INIT;
                        OP_CLEAR:   n_state = S_CLR_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_EXP_RD:   n_state = i_sts.held_zero ? S_SRCH_RD : S_EXP_CHK;
            S_EXP_CHK: begin
                if (!i_sts.expired) n_state = S_SRCH_RD;
                else if (i_sts.held_one) n_state = S_EXP_RD;
                else n_state = S_EXP_MRD;
            end
            S_EXP_MRD:  n_state = S_EXP_MLD;
            S_EXP_MLD: begin
                n_state = S_SD_RDL;
                n_ret   = S_EXP_RD;
            end
            S_SD_RDL:   n_state = i_sts.l_ok ? S_SD_CHL : S_WR_CUR;
            S_SD_CHL:   n_state = i_sts.r_ok ? S_SD_CHR : S_SD_DEC;
            S_SD_CHR:   n_state = S_SD_DEC;
            S_SD_DEC:   n_state = i_sts.s_is_i ? S_WR_CUR : S_SD_RDL;
            S_WR_CUR:   n_state = r_ret;
            S_SU_RDP:   n_state = i_sts.i_zero ? S_WR_CUR : S_SU_CHP;
            S_SU_CHP:   n_state = i_sts.up_less ? S_SU_RDP : S_WR_CUR;
            S_SRCH_RD:  n_state = i_sts.j_end ? S_DEC_RD : S_SRCH_CHK;
            S_SRCH_CHK: n_state = i_sts.key_match ? S_DEC_RD : S_SRCH_RD;
            S_DEC_RD:   n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_sts.found) begin
                    n_state = S_SD_RDL;
                    n_ret   = S_UPD_RD;
                end else if (i_sts.room) begin
                    n_state = S_SU_RDP;
                    n_ret   = S_STAT;
                end else if (i_sts.beats) begin
                    n_state = S_SD_RDL;
                    n_ret   = S_STAT;
                end else begin
                    n_state = S_STAT;
                end
            end
            S_UPD_RD:   n_state = S_UPD_LD;
            S_UPD_LD: begin
                n_state = S_SU_RDP;
                n_ret   = S_STAT;
            end
            S_STAT:     n_state = S_DRN_RD;
            S_RPT_INIT: n_state = i_sts.held_zero ? S_DRN_RD : S_RPT_SI;
            S_RPT_SI:   n_state = S_RPT_RD;
            S_RPT_RD:   n_state = i_sts.j_end ? S_RPT_EMIT : S_RPT_CHK;
            S_RPT_CHK:  n_state = S_RPT_RD;
            S_RPT_EMIT: n_state = i_sts.rpt_last ? S_DRN_RD : S_RPT_SI;
            S_CLR_RD:   n_state = i_sts.j_end ? S_CLR_DONE : S_CLR_PUSH;
            S_CLR_PUSH: n_state = S_CLR_RD;
            S_CLR_DONE: n_state = S_DRN_RD;
            S_DRN_RD:   n_state = S_DRN_OUT;
            S_DRN_OUT:  n_state = S_DRN_WAIT;
            S_DRN_WAIT: begin
                if (i_sts.out_done) n_state = i_sts.drn_last ? S_IDLE : S_DRN_RD;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op   = DP_NOP;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = DP_LOAD;
            end
            S_EXP_RD:   o_cmd.op = DP_EXP_RD;
            S_EXP_CHK:  o_cmd.op = DP_EXP_CHK;
            S_EXP_MRD:  o_cmd.op = DP_EXP_MRD;
            S_EXP_MLD:  o_cmd.op = DP_EXP_MLD;
            S_SD_RDL:   o_cmd.op = DP_SD_RDL;
            S_SD_CHL:   o_cmd.op = DP_SD_CHL;
            S_SD_CHR:   o_cmd.op = DP_SD_CHR;
            S_SD_DEC:   o_cmd.op = DP_SD_DEC;
            S_WR_CUR:   o_cmd.op = DP_WR_CUR;
            S_SU_RDP:   o_cmd.op = DP_SU_RDP;
            S_SU_CHP:   o_cmd.op = DP_SU_CHP;
            S_SRCH_RD:  o_cmd.op = DP_SRCH_RD;
            S_SRCH_CHK: o_cmd.op = DP_SRCH_CHK;
            S_DEC_RD:   o_cmd.op = DP_DEC_RD;
            S_DECIDE: begin
                if (i_sts.found) o_cmd.op = DP_DEC_UPD;
                else if (i_sts.room) o_cmd.op = DP_DEC_INS;
                else if (i_sts.beats) o_cmd.op = DP_DEC_REP;
                else o_cmd.op = DP_DEC_DROP;
            end
            S_UPD_RD:   o_cmd.op = DP_UPD_RD;
            S_UPD_LD:   o_cmd.op = DP_UPD_LD;
            S_STAT:     o_cmd.op = DP_STAT;
            S_RPT_INIT: o_cmd.op = DP_RPT_INIT;
            S_RPT_SI:   o_cmd.op = DP_RPT_SI;
            S_RPT_RD:   o_cmd.op = DP_RPT_RD;
            S_RPT_CHK:  o_cmd.op = DP_RPT_CHK;
            S_RPT_EMIT: o_cmd.op = DP_RPT_EMIT;
            S_CLR_RD:   o_cmd.op = DP_CLR_RD;
            S_CLR_PUSH: o_cmd.op = DP_CLR_PUSH;
            S_CLR_DONE: o_cmd.op = DP_CLR_DONE;
            S_DRN_RD:   o_cmd.op = DP_DRN_RD;
            S_DRN_OUT:  o_cmd.op = DP_DRN_OUT;
            S_DRN_WAIT: o_cmd.op = DP_NOP;
            default:    o_cmd.op = DP_NOP;
        endcase
    end

endmodule

### rtl/core/stkx_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkx_dp
// Heap store, key search, sift and sort datapath with the result queue.
// ----------------------------------------------------------------------------
module stkx_dp #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stkx_pkg::t_dp_cmd  i_cmd,
    output stkx_pkg::t_dp_sts  o_sts,
    input  logic [31:0]        i_key,
    input  logic signed [31:0] i_sample,
    input  logic [31:0]        i_now,
    input  logic [4:0]         i_k_in_use,
    input  logic [23:0]        i_ttl,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [2:0]         o_kind,
    output logic [31:0]        o_key,
    output logic [31:0]        o_value,
    output logic [31:0]        o_timestamp,
    output logic [31:0]        o_hits,
    output logic [1:0]         o_status,
    output logic [4:0]         o_occupancy,
    output logic               o_last
);
    import stkx_pkg::*;

    localparam int HW  = $clog2(CAPACITY + 1);
    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VB  = VALUE_BITS;
    localparam int EW  = 96 + VB;
    localparam int QD  = CAPACITY + 2;
    localparam int QW  = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);
    localparam int QEW = 133;
    localparam logic [63:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF >> (64 - VB);
    localparam logic [63:0] VMIN = ~VMAX;

    // Queue entry from the lowest bit up: kind, key, value, time, hits, status.
    function automatic logic [QEW-1:0] q_pack(input logic [2:0] kind, input logic [31:0] key,
                                              input logic [31:0] val, input logic [31:0] tim,
                                              input logic [31:0] hit, input logic [1:0] st);
        q_pack = {st, hit, tim, val, key, kind};
    endfunction

    function automatic logic [31:0] low32(input logic [VB-1:0] v);
        logic [63:0] x;
        x = 64'($signed(v));
        low32 = x[31:0];
    endfunction

    // Heap entry: key in the low bits, then value, time and hits.
    logic [EW-1:0]  mem [CAPACITY];
    logic [QEW-1:0] q   [QD];

    logic [EW-1:0]  r_rd, r_child, r_best;
    logic [QEW-1:0] r_qrd;
    logic [HW-1:0]  r_held, r_idx, r_s, r_j, r_fidx, r_bidx, r_emit;
    logic [31:0]    r_key, r_now, r_cur_key, r_cur_time, r_cur_hits, r_h;
    logic [VB-1:0]  r_val, r_cur_val, r_sval;
    logic [1:0]     r_status;
    logic           r_found, r_bvalid;
    logic [CAPACITY-1:0] r_done;
    logic [QCW-1:0] r_qcnt, r_qr;

    logic           r_ovalid, r_olast;
    logic [2:0]     r_okind;
    logic [31:0]    r_okey, r_oval, r_otime, r_ohits;
    logic [1:0]     r_ostatus;
    logic [4:0]     r_oocc;

    logic [31:0]    rd_key, rd_time, rd_hits, b_key;
    logic [VB-1:0]  rd_val, b_val;
    logic [HW:0]    lidx, ridx;
    logic [HW-1:0]  pidx, keff;
    logic [63:0]    s64;
    logic [VB-1:0]  sat;
    logic [EW-1:0]  cur_e, new_e;
    logic [31:0]    hits_inc;
    logic           better;

    logic           mem_re, mem_we, q_we;
    logic [IW-1:0]  raddr, waddr;
    logic [EW-1:0]  wdata;
    logic [QEW-1:0] q_wdata;

    assign rd_key  = r_rd[31:0];
    assign rd_val  = r_rd[32 +: VB];
    assign rd_time = r_rd[32+VB +: 32];
    assign rd_hits = r_rd[64+VB +: 32];
    assign b_key   = r_best[31:0];
    assign b_val   = r_best[32 +: VB];
    assign lidx    = {r_idx, 1'b1};
    assign ridx    = lidx + 1'b1;
    assign pidx    = (r_idx - 1'b1) >> 1;
    assign cur_e   = {r_cur_hits, r_cur_time, r_cur_val, r_cur_key};
    assign new_e   = {32'd1, r_now, r_val, r_key};
    assign hits_inc = (r_cur_hits == 32'hFFFF_FFFF) ? r_cur_hits : r_cur_hits + 32'd1;
    assign better  = ($signed(rd_val) > $signed(b_val)) ||
                     ((rd_val == b_val) && (rd_key < b_key));

    always_comb begin
        s64 = 64'(i_sample);
        if ($signed(s64) > $signed(VMAX)) sat = VMAX[VB-1:0];
        else if ($signed(s64) < $signed(VMIN)) sat = VMIN[VB-1:0];
        else sat = s64[VB-1:0];
    end

    always_comb begin
        if (i_k_in_use == 5'd0) keff = HW'(1);
        else if (32'(i_k_in_use) > CAPACITY) keff = HW'(CAPACITY);
        else keff = HW'(i_k_in_use);
    end

    // Expiry when time + ttl < now, tested unsigned in 33 bits so the sum cannot wrap.
    always_comb begin
        o_sts.held_zero = (r_held == '0);
        o_sts.held_one  = (r_held == HW'(1));
        o_sts.j_end     = (r_j >= r_held);
        o_sts.expired   = ({1'b0, rd_time} + 33'(i_ttl)) < {1'b0, r_now};
        o_sts.l_ok      = (lidx < {1'b0, r_held});
        o_sts.r_ok      = (ridx < {1'b0, r_held});
        o_sts.s_is_i    = (r_s == r_idx);
        o_sts.i_zero    = (r_idx == '0);
        o_sts.key_match = (rd_key == r_key);
        o_sts.found     = r_found;
        o_sts.room      = (r_held < keff);
        o_sts.beats     = (r_held != '0) && ($signed(r_val) > $signed(rd_val));
        o_sts.up_less   = ($signed(r_cur_val) < $signed(rd_val));
        o_sts.rpt_last  = ((r_emit + 1'b1) == r_held);
        o_sts.drn_last  = r_olast;
        o_sts.out_done  = r_ovalid && i_out_ready;
    end

    always_comb begin
        mem_re  = 1'b0;
        raddr   = '0;
        mem_we  = 1'b0;
        waddr   = r_idx[IW-1:0];
        wdata   = cur_e;
        q_we    = 1'b0;
        q_wdata = q_pack(KIND_EXPIRED, rd_key, low32(rd_val), rd_time, rd_hits, ST_UPDATED);
        case (i_cmd.op)
            DP_EXP_RD, DP_DEC_RD: begin
                mem_re = 1'b1;
            end
            DP_EXP_CHK: q_we = o_sts.expired;
            DP_EXP_MRD: begin
                mem_re = 1'b1;
                raddr  = r_held[IW-1:0];
            end
            DP_SD_RDL: begin
                mem_re = 1'b1;
                raddr  = lidx[IW-1:0];
            end
            DP_SD_CHL: begin
                mem_re = 1'b1;
                raddr  = ridx[IW-1:0];
            end
            DP_SD_DEC: begin
                mem_we = !o_sts.s_is_i;
                wdata  = r_child;
            end
            DP_WR_CUR: mem_we = 1'b1;
            DP_SU_RDP: begin
                mem_re = 1'b1;
                raddr  = pidx[IW-1:0];
            end
            DP_SU_CHP: begin
                mem_we = o_sts.up_less;
                wdata  = r_rd;
            end
            DP_SRCH_RD, DP_RPT_RD, DP_CLR_RD: begin
                mem_re = 1'b1;
                raddr  = r_j[IW-1:0];
            end
            DP_UPD_RD: begin
                mem_re = 1'b1;
                raddr  = r_fidx[IW-1:0];
            end
            DP_DEC_REP: begin
                q_we    = 1'b1;
                q_wdata = q_pack(KIND_DISPLACED, rd_key, low32(rd_val), rd_time, rd_hits,
                                 ST_UPDATED);
            end
            DP_STAT: begin
                q_we    = 1'b1;
                q_wdata = q_pack(KIND_STATUS, r_key, low32(r_val), r_now, r_h, r_status);
            end
            DP_RPT_INIT: begin
                q_we    = o_sts.held_zero;
                q_wdata = q_pack(KIND_EMPTY, '0, '0, '0, '0, ST_UPDATED);
            end
            DP_RPT_EMIT: begin
                q_we    = 1'b1;
                q_wdata = q_pack(KIND_REPORT, b_key, low32(b_val), r_best[32+VB +: 32],
                                 r_best[64+VB +: 32], ST_UPDATED);
            end
            DP_CLR_PUSH: q_we = 1'b1;
            DP_CLR_DONE: begin
                q_we    = 1'b1;
                q_wdata = q_pack(KIND_CLEAR, '0, '0, '0, '0, ST_UPDATED);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[waddr] <= wdata;
        if (mem_re) r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) q[r_qcnt[QW-1:0]] <= q_wdata;
        if (i_cmd.op == DP_DRN_RD) r_qrd <= q[r_qr[QW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_ovalid <= 1'b0;
            r_qcnt   <= '0;
            r_qr     <= '0;
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (q_we) r_qcnt <= r_qcnt + 1'b1;
            case (i_cmd.op)
                DP_LOAD: begin
                    r_key   <= i_key;
                    r_val   <= sat;
                    r_now   <= i_now;
                    r_j     <= '0;
                    r_found <= 1'b0;
                    r_qcnt  <= '0;
                    r_qr    <= '0;
                end
                DP_EXP_CHK: begin
                    if (o_sts.expired) r_held <= r_held - 1'b1;
                end
                DP_EXP_MLD, DP_UPD_LD: begin
                    r_cur_key  <= rd_key;
                    r_cur_val  <= rd_val;
                    r_cur_time <= rd_time;
                    r_cur_hits <= rd_hits;
                    r_idx      <= (i_cmd.op == DP_UPD_LD) ? r_fidx : '0;
                end
                DP_SD_CHL: begin
                    if ($signed(rd_val) < $signed(r_cur_val)) begin
                        r_s     <= HW'(lidx);
                        r_sval  <= rd_val;
                        r_child <= r_rd;
                    end else begin
                        r_s    <= r_idx;
                        r_sval <= r_cur_val;
                    end
                end
                DP_SD_CHR: begin
                    if ($signed(rd_val) < $signed(r_sval)) begin
                        r_s     <= HW'(ridx);
                        r_child <= r_rd;
                    end
                end
                DP_SD_DEC: begin
                    if (!o_sts.s_is_i) r_idx <= r_s;
                end
                DP_SU_CHP: begin
                    if (o_sts.up_less) r_idx <= pidx;
                end
                DP_SRCH_CHK: begin
                    if (o_sts.key_match) begin
                        r_found    <= 1'b1;
                        r_fidx     <= r_j;
                        r_cur_key  <= rd_key;
                        r_cur_val  <= rd_val;
                        r_cur_time <= rd_time;
                        r_cur_hits <= rd_hits;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                DP_DEC_UPD: begin
                    r_cur_val  <= r_val;
                    r_cur_time <= r_now;
                    r_cur_hits <= hits_inc;
                    r_h        <= hits_inc;
                    r_status   <= ST_UPDATED;
                    r_idx      <= r_fidx;
                end
                DP_DEC_INS, DP_DEC_REP: begin
                    r_cur_key  <= r_key;
                    r_cur_val  <= r_val;
                    r_cur_time <= r_now;
                    r_cur_hits <= 32'd1;
                    r_h        <= 32'd1;
                    if (i_cmd.op == DP_DEC_INS) begin
                        r_idx    <= r_held;
                        r_held   <= r_held + 1'b1;
                        r_status <= ST_INSERTED;
                    end else begin
                        r_idx    <= '0;
                        r_status <= ST_REPLACED;
                    end
                end
                DP_DEC_DROP: begin
                    r_h      <= 32'd0;
                    r_status <= ST_DROPPED;
                end
                DP_RPT_INIT: begin
                    r_done <= '0;
                    r_emit <= '0;
                end
                DP_RPT_SI: begin
                    r_j      <= '0;
                    r_bvalid <= 1'b0;
                end
                DP_RPT_CHK: begin
                    if (!r_done[r_j[IW-1:0]] && (!r_bvalid || better)) begin
                        r_best   <= r_rd;
                        r_bidx   <= r_j;
                        r_bvalid <= 1'b1;
                    end
                    r_j <= r_j + 1'b1;
                end
                DP_RPT_EMIT: begin
                    r_done[r_bidx[IW-1:0]] <= 1'b1;
                    r_emit <= r_emit + 1'b1;
                end
                DP_CLR_PUSH: r_j <= r_j + 1'b1;
                DP_CLR_DONE: r_held <= '0;
                DP_DRN_OUT: begin
                    r_okind   <= r_qrd[2:0];
                    r_okey    <= r_qrd[34:3];
                    r_oval    <= r_qrd[66:35];
                    r_otime   <= r_qrd[98:67];
                    r_ohits   <= r_qrd[130:99];
                    r_ostatus <= r_qrd[132:131];
                    r_oocc    <= 5'(r_held);
                    r_olast   <= ((r_qr + 1'b1) == r_qcnt);
                    r_ovalid  <= 1'b1;
                    r_qr      <= r_qr + 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_okind;
    assign o_key       = r_okey;
    assign o_value     = r_oval;
    assign o_timestamp = r_otime;
    assign o_hits      = r_ohits;
    assign o_status    = r_ostatus;
    assign o_occupancy = r_oocc;
    assign o_last      = r_olast;

endmodule

### rtl/core/streaming_top_k_with_expiry_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_top_k_with_expiry_unit
// Top-K min-heap store with expiry, sorted report and clear.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Contents
// s_axis    in         tvalid/tready       operation, key, sample, time
// m_axis    out        tvalid/tready/tlast result items of one request
// apb       in         psel/penable        k_in_use, ttl
//
// One request at a time. The heap lives in a single-port memory, so a key
// search reads one slot at a time, expired entries are taken from the root
// one by one with the last slot moved up and sifted down, and a report scans
// every held slot per entry. Results are queued, then sent one at a time.
// Reset is synchronous; no clearing pass is needed as only held slots are read.
// ----------------------------------------------------------------------------
module streaming_top_k_with_expiry_unit #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,   // key, sample_value, now_seconds
    input  logic [1:0]   i_s_axis_tuser,   // operation
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [135:0] o_m_axis_tdata,   // out_key, out_value, out_timestamp,
                                           // hits, status, occupancy, zero pad
    output logic [2:0]   o_m_axis_tuser,   // kind
    output logic         o_m_axis_tlast,   // last
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);
    import stkx_pkg::*;

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [4:0]  r_k_in_use;
    logic [23:0] r_ttl;
    logic [31:0] key, value, tstamp, hits;
    logic [1:0]  status;
    logic [4:0]  occ;
    logic        cfg_wr;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    // A new k is only taken while the store is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_in_use <= K_RESET;
            r_ttl      <= TTL_RESET;
        end else if (cfg_wr) begin
            unique case (i_paddr[2])
                REG_K_IN_USE: if (sts.held_zero) r_k_in_use <= i_pwdata[4:0];
                REG_TTL:      r_ttl <= i_pwdata[23:0];
                default: ;
            endcase
        end
    end

    assign o_prdata = (i_paddr[2] == REG_TTL) ? {8'd0, r_ttl} : {27'd0, r_k_in_use};

    stkx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_op    (i_s_axis_tuser),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_s_axis_tready)
    );

    stkx_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_key       (i_s_axis_tdata[31:0]),
        .i_sample    (i_s_axis_tdata[63:32]),
        .i_now       (i_s_axis_tdata[95:64]),
        .i_k_in_use  (r_k_in_use),
        .i_ttl       (r_ttl),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_kind      (o_m_axis_tuser),
        .o_key       (key),
        .o_value     (value),
        .o_timestamp (tstamp),
        .o_hits      (hits),
        .o_status    (status),
        .o_occupancy (occ),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, occ, status, hits, tstamp, value, key};

    // No request is taken while a result is still on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> !o_m_axis_tvalid)
        else $error("request accepted while a result is pending");

    // Status, empty report and clear done always close a request.
    a_closing_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_STATUS ||
         o_m_axis_tuser == KIND_EMPTY || o_m_axis_tuser == KIND_CLEAR)) |-> o_m_axis_tlast)
        else $error("closing kind without last");

    // An unused operation leaves the block ready at once.
    a_unused_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == OP_UNUSED)
        |=> o_s_axis_tready)
        else $error("unused operation stalled the input");

endmodule

### bench/stkx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkx_checker
// Watches the request, result and register channels of the top-K store,
// keeps its own copy of the heap and registers, predicts the results of
// every accepted request and compares each delivered result with them.
// ----------------------------------------------------------------------------
module stkx_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [95:0]  i_s_tdata,
    input  logic [1:0]   i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [135:0] i_m_tdata,
    input  logic [2:0]   i_m_tuser,
    input  logic         i_m_tlast,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    input  logic         i_pready,
    output int           o_fail_count,
    output int           o_pending
);
    import stkx_pkg::*;

    localparam int SLOTS = 16;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] key;
        logic [31:0] value;
        logic [31:0] stamp;
        logic [31:0] hits;
        logic [1:0]  status;
        logic [4:0]  occ;
        logic        last;
    } t_result;

    t_result            pending_results[$];
    t_result            item_results[$];

    logic [31:0]        heap_key   [SLOTS];
    logic signed [31:0] heap_value [SLOTS];
    logic [31:0]        heap_stamp [SLOTS];
    logic [31:0]        heap_hits  [SLOTS];
    int                 heap_size;
    logic [4:0]         k_reg;
    logic [23:0]        ttl_reg;
    int                 fails;
    int                 pend_count;

    initial begin
        fails = 0;
        pend_count = 0;
        heap_size = 0;
        k_reg = K_RESET;
        ttl_reg = TTL_RESET;
    end

    assign o_fail_count = fails;
    assign o_pending    = pend_count;

    function automatic void swap_slots(input int a, input int b);
        logic [31:0] tk, tt, th;
        logic signed [31:0] tv;
        tk = heap_key[a]; tv = heap_value[a]; tt = heap_stamp[a]; th = heap_hits[a];
        heap_key[a] = heap_key[b]; heap_value[a] = heap_value[b];
        heap_stamp[a] = heap_stamp[b]; heap_hits[a] = heap_hits[b];
        heap_key[b] = tk; heap_value[b] = tv; heap_stamp[b] = tt; heap_hits[b] = th;
    endfunction

    function automatic void sift_up(input int start);
        int i, p;
        i = start;
        while (i > 0 && i < heap_size) begin
            p = (i - 1) / 2;
            if (heap_value[i] < heap_value[p]) begin
                swap_slots(i, p);
                i = p;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void sift_down(input int start);
        int i, s, l, r;
        i = start;
        while (i < heap_size) begin
            s = i; l = 2 * i + 1; r = 2 * i + 2;
            if (l < heap_size && heap_value[l] < heap_value[s]) s = l;
            if (r < heap_size && heap_value[r] < heap_value[s]) s = r;
            if (s == i) break;
            swap_slots(i, s);
            i = s;
        end
    endfunction

    function automatic void add_result(input logic [2:0] kind, input logic [31:0] key,
                                       input logic [31:0] value, input logic [31:0] stamp,
                                       input logic [31:0] hits, input logic [1:0] status);
        t_result r;
        r.kind = kind; r.key = key; r.value = value; r.stamp = stamp;
        r.hits = hits; r.status = status; r.occ = '0; r.last = 1'b0;
        item_results.insert(item_results.size(), r);
    endfunction

    function automatic void add_slot(input logic [2:0] kind, input int i);
        add_result(kind, heap_key[i], heap_value[i], heap_stamp[i], heap_hits[i], ST_UPDATED);
    endfunction

    // Works out the results of one request and moves them to the pending list.
    function automatic void predict_request(input logic [1:0] op, input logic [31:0] key,
                                            input logic signed [31:0] sample,
                                            input logic [31:0] now);
        longint limit;
        int k_eff, j, p, x, y, found_at;
        int order [SLOTS];
        logic [31:0] h;
        logic [1:0] st;
        logic ahead;
        t_result r;
        item_results.delete();
        if (op == OP_OBSERVE) begin
            limit = longint'(now) - longint'(ttl_reg);
            h = '0;
            while (heap_size > 0 && longint'(heap_stamp[0]) < limit) begin
                add_slot(KIND_EXPIRED, 0);
                heap_size--;
                if (heap_size > 0) begin
                    heap_key[0] = heap_key[heap_size]; heap_value[0] = heap_value[heap_size];
                    heap_stamp[0] = heap_stamp[heap_size]; heap_hits[0] = heap_hits[heap_size];
                    sift_down(0);
                end
            end
            found_at = -1;
            for (j = 0; j < heap_size; j++) begin
                if (found_at < 0 && heap_key[j] == key) found_at = j;
            end
            k_eff = (k_reg < 1) ? 1 : ((k_reg > SLOTS) ? SLOTS : int'(k_reg));
            if (found_at >= 0) begin
                heap_value[found_at] = sample;
                heap_stamp[found_at] = now;
                if (heap_hits[found_at] != 32'hFFFF_FFFF) heap_hits[found_at]++;
                h = heap_hits[found_at];
                sift_down(found_at);
                sift_up(found_at);
                st = ST_UPDATED;
            end else if (heap_size < k_eff) begin
                p = heap_size;
                heap_key[p] = key; heap_value[p] = sample; heap_stamp[p] = now;
                heap_hits[p] = 1;
                heap_size++;
                sift_up(p);
                h = 1;
                st = ST_INSERTED;
            end else if (heap_size > 0 && sample > heap_value[0]) begin
                add_slot(KIND_DISPLACED, 0);
                heap_key[0] = key; heap_value[0] = sample; heap_stamp[0] = now;
                heap_hits[0] = 1;
                sift_down(0);
                h = 1;
                st = ST_REPLACED;
            end else begin
                st = ST_DROPPED;
            end
            add_result(KIND_STATUS, key, sample, now, h, st);
        end else if (op == OP_REPORT) begin
            for (j = 0; j < heap_size; j++) begin
                x = j; p = j;
                while (p > 0) begin
                    y = order[p - 1];
                    ahead = heap_value[x] > heap_value[y] ||
                            (heap_value[x] == heap_value[y] && heap_key[x] < heap_key[y]);
                    if (!ahead) break;
                    order[p] = y;
                    p--;
                end
                order[p] = x;
            end
            if (heap_size == 0) add_result(KIND_EMPTY, '0, '0, '0, '0, ST_UPDATED);
            for (j = 0; j < heap_size; j++) add_slot(KIND_REPORT, order[j]);
        end else if (op == OP_CLEAR) begin
            for (j = 0; j < heap_size; j++) add_slot(KIND_EXPIRED, j);
            heap_size = 0;
            add_result(KIND_CLEAR, '0, '0, '0, '0, ST_UPDATED);
        end
        // The remaining operation code is ignored by the block.
        for (j = 0; j < item_results.size(); j++) begin
            r = item_results[j];
            r.occ = heap_size[4:0];
            r.last = (j == item_results.size() - 1);
            pending_results.insert(pending_results.size(), r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n) begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_K_IN_USE) begin
                    if (heap_size == 0) k_reg = i_pwdata[4:0];
                end else begin
                    ttl_reg = i_pwdata[23:0];
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_request(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[95:64]);
            if (i_m_tvalid && i_m_tready) begin
                got.kind = i_m_tuser;
                got.key = i_m_tdata[31:0];
                got.value = i_m_tdata[63:32];
                got.stamp = i_m_tdata[95:64];
                got.hits = i_m_tdata[127:96];
                got.status = i_m_tdata[129:128];
                got.occ = i_m_tdata[134:130];
                got.last = i_m_tlast;
                if (pending_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result: kind %0d key %h", got.kind, got.key);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.key !== want.key ||
                        got.value !== want.value || got.stamp !== want.stamp ||
                        got.hits !== want.hits || got.status !== want.status ||
                        got.occ !== want.occ || got.last !== want.last) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp kind %0d key %h val %h ts %h hits %h",
                                     want.kind, want.key, want.value, want.stamp, want.hits,
                                     " st %0d occ %0d last %0d", want.status, want.occ,
                                     want.last,
                                     " / got kind %0d key %h val %h ts %h hits %h",
                                     got.kind, got.key, got.value, got.stamp, got.hits,
                                     " st %0d occ %0d last %0d", got.status, got.occ,
                                     got.last);
                    end
                end
            end
            pend_count = pending_results.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests and register writes into the top-K store with random
// stalls on both sides, a long output hold-off and idle pauses, and gives
// the verdict from the checker's mismatch count or fails a run that hangs.
// ----------------------------------------------------------------------------
module testbench;
    import stkx_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_valid;
    logic         s_ready;
    logic [95:0]  s_data;
    logic [1:0]   s_user;
    logic         m_valid;
    logic         m_ready;
    logic [135:0] m_data;
    logic [2:0]   m_user;
    logic         m_last;
    logic         psel, penable, pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;
    bit           no_idle;
    bit           hold_req;
    logic [31:0]  now_s;
    logic [31:0]  host_pool [24];
    int           cycles;

    streaming_top_k_with_expiry_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user), .o_m_axis_tlast(m_last),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    stkx_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data), .i_s_tuser(s_user),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_m_tuser(m_user), .i_m_tlast(m_last),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Result receiver: random stall bursts, and one long hold-off on request.
    initial begin
        int stall_left, ready_left;
        stall_left = 0;
        ready_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 500;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (ready_left > 0) begin
                m_ready <= 1'b1;
                ready_left--;
            end else if (!no_idle && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end else begin
                m_ready <= 1'b1;
                ready_left = $urandom_range(0, 20);
            end
        end
    end

    task automatic send_req(input logic [1:0] op, input logic [31:0] key,
                            input logic [31:0] sample, input logic [31:0] now);
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {now, sample, key};
        do @(posedge i_clk); while (!s_ready);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // Allow for a request that causes no result still being worked on.
        repeat (60) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic observe(input logic [31:0] key, input logic [31:0] sample);
        send_req(OP_OBSERVE, key, sample, now_s);
    endtask

    // One random request: mostly observations on a pool of hosts with a
    // slowly advancing clock, with reports, clears and noise mixed in.
    task automatic random_req();
        int pick;
        logic [31:0] sample;
        pick = $urandom_range(0, 99);
        now_s = now_s + $urandom_range(0, 3);
        if ($urandom_range(0, 2) == 0) sample = $urandom_range(0, 7) << 16;
        else sample = $urandom;
        if (pick < 78) observe(host_pool[$urandom_range(0, 23)], sample);
        else if (pick < 86) send_req(OP_REPORT, $urandom, $urandom, $urandom);
        else if (pick < 89) send_req(OP_CLEAR, $urandom, $urandom, $urandom);
        else if (pick < 92) send_req(OP_UNUSED, $urandom, $urandom, $urandom);
        else if (pick < 96) observe($urandom, sample);
        else send_req(OP_OBSERVE, host_pool[$urandom_range(0, 23)], sample, $urandom);
    endtask

    initial begin
        int phase, n;
        logic [4:0] k_set [6];
        logic [23:0] ttl_set [6];
        k_set = '{5'd1, 5'd16, 5'd4, 5'd0, 5'd31, 5'd7};
        ttl_set = '{24'd5, 24'd16777215, 24'd1, 24'd20, 24'd8, 24'd3600};
        no_idle = 1'b0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = OP_OBSERVE;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        now_s = 32'd100;
        for (n = 0; n < 24; n++) host_pool[n] = $urandom;
        host_pool[0] = 32'h0;
        host_pool[1] = 32'hFFFF_FFFF;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with reset settings (k of 10, ttl of 3600).
        send_req(OP_REPORT, '0, '0, '0);
        send_req(OP_CLEAR, '0, '0, '0);
        send_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        observe(32'h0, 32'h8000_0000);
        observe(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        for (n = 2; n < 10; n++) observe(host_pool[n], n << 16);
        observe(32'h1234_5678, 32'h0001_0000);   // full, larger than minimum
        observe(32'h8765_4321, 32'h8000_0000);   // full, not larger: dropped
        observe(host_pool[5], 32'h0);            // update of a held key
        observe(host_pool[6], 32'h0);            // tie in value
        send_req(OP_REPORT, '0, '0, '0);
        wait_idle();
        reg_write(3'd0, 32'd3);                  // ignored while entries are held
        now_s = 32'd100000;                      // everything has aged out
        observe(32'hABCD_0001, 32'h0002_0000);
        send_req(OP_REPORT, '0, '0, '0);
        send_req(OP_CLEAR, '0, '0, '0);
        now_s = 32'hFFFF_FFF0;
        observe(host_pool[3], 32'h0003_0000);
        observe(host_pool[3], 32'h0004_0000);
        send_req(OP_OBSERVE, host_pool[3], 32'h1, 32'h0);   // time going backwards
        send_req(OP_REPORT, '0, '0, '0);
        wait_idle();

        for (phase = 0; phase < 6; phase++) begin
            send_req(OP_CLEAR, '0, '0, '0);
            wait_idle();
            reg_write(3'd0, {27'd0, k_set[phase]});
            reg_write(3'd4, {8'hFF, ttl_set[phase]});
            if (phase == 3) now_s = 32'hFFFF_FF00;
            if (phase == 5) no_idle = 1'b1;
            if (phase == 2) begin
                // Long output hold-off while requests keep coming.
                hold_req = 1'b1;
                for (n = 0; n < 20; n++) begin
                    now_s = now_s + 1;
                    observe(host_pool[$urandom_range(0, 23)], $urandom);
                end
                send_req(OP_REPORT, '0, '0, '0);
                wait_idle();
            end
            for (n = 0; n < 45; n++) random_req();
            wait_idle();
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
